/* design/mbet_pkg.sv */
// mbet_pkg: widths, constants and a saturation helper function for the escape-time block
// no dependencies
`default_nettype none

package mbet_pkg;

   // fixed point format and coordinate handling
   localparam int FRACTION_BITS = 28;
   localparam int COORD_BITS    = 12;

   // field widths
   localparam int DATA_W  = 32;
   localparam int STEP_W  = 31;
   localparam int PIX_W   = 12;
   localparam int COUNT_W = 12;
   localparam int IDX_W   = 3;

   // shared multiplier: 33x33 signed covers 32-bit signed and 31-bit unsigned operands
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   // register indexes
   localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_STEP_X   = 3'd2;
   localparam logic [IDX_W-1:0] REG_STEP_Y   = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd4;

   // register reset values
   localparam logic signed [DATA_W-1:0] ORIGIN_X_RST = -32'sd563714458;
   localparam logic signed [DATA_W-1:0] ORIGIN_Y_RST = -32'sd335544320;
   localparam logic [STEP_W-1:0]        STEP_X_RST   = 31'd1468006;
   localparam logic [STEP_W-1:0]        STEP_Y_RST   = 31'd1310720;
   localparam logic [COUNT_W-1:0]       MAX_ITER_RST = 12'd511;

   // low COORD_BITS bits of a pixel index are used
   localparam logic [PIX_W-1:0] COORD_MASK =
      (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

   // escape when |z|^2 >= 4 in the squared scale
   localparam logic signed [PROD_W-1:0] ESC_LIMIT =
      PROD_W'(1) << (2 * FRACTION_BITS + 2);

   // signed 32-bit saturation bounds
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32'h7fff_ffff);
   localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/mandelbrot_escape_time.sv */
// from an accepted request beat: coordinate products, then the iterations, then the response beat
// one shared 33x33 multiplier does x*x, y*y, x*y in turn, so each iteration takes
//   three products and the update
// the request side stalls while a pixel is in work; the response sits in an output register
// reset (synchronous, active high) loads the default view registers and empties the block
`default_nettype none

module mandelbrot_escape_time (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [mbet_pkg::PIX_W-1:0]          req_pixel_column,
   input  wire  [mbet_pkg::PIX_W-1:0]          req_pixel_row,
   // response channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [mbet_pkg::COUNT_W-1:0]        rsp_escape_count,
   // register write channel
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [mbet_pkg::IDX_W-1:0]          csr_index,
   input  wire  [mbet_pkg::DATA_W-1:0]         csr_wdata
);
   import mbet_pkg::*;

   // sequencer: one-hot states
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,   // waiting for a request beat
      ST_MCX  = 9'b000000010,   // column * step_x
      ST_MCY  = 9'b000000100,   // row * step_y, c_real resolved
      ST_LDC  = 9'b000001000,   // c_imag resolved, z = c
      ST_SQX  = 9'b000010000,   // x * x
      ST_SQY  = 9'b000100000,   // y * y
      ST_CRS  = 9'b001000000,   // x * y, escape and limit test
      ST_UPD  = 9'b010000000,   // z = z^2 + c
      ST_DONE = 9'b100000000    // hand the count to the response register
   } state_type;

   state_type state_ff, state_in;

   // view registers
   logic signed [DATA_W-1:0] origin_x_ff, origin_y_ff;
   logic [STEP_W-1:0]        step_x_ff, step_y_ff;
   logic [COUNT_W-1:0]       max_iter_ff;

   // per-pixel working registers
   logic [PIX_W-1:0]         col_ff, row_ff;
   logic signed [DATA_W-1:0] c_real_ff, c_imag_ff, x_ff, y_ff;
   logic signed [DATA_W-1:0] c_real_in, c_imag_in, x_in, y_in;
   logic signed [PROD_W-1:0] prod_ff, xx_ff, yy_ff;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in;

   // sign-extended operands for the adders
   logic signed [PROD_W-1:0] origin_x_ext, origin_y_ext, c_real_ext, c_imag_ext;
   logic signed [PROD_W-1:0] re_diff, re_shf, im_shf, esc_sum;

   logic req_beat, rsp_free, escaped, at_limit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;
   // the response slot can take a new count when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // operand select for the one multiplier
   always_comb begin
      mul_a = {{(MUL_W-DATA_W){x_ff[DATA_W-1]}}, x_ff};
      mul_b = {{(MUL_W-DATA_W){x_ff[DATA_W-1]}}, x_ff};
      case (state_ff)
         ST_MCX: begin
            mul_a = {{(MUL_W-PIX_W){1'b0}}, col_ff};
            mul_b = {{(MUL_W-STEP_W){1'b0}}, step_x_ff};
         end
         ST_MCY: begin
            mul_a = {{(MUL_W-PIX_W){1'b0}}, row_ff};
            mul_b = {{(MUL_W-STEP_W){1'b0}}, step_y_ff};
         end
         ST_SQY: begin
            mul_a = {{(MUL_W-DATA_W){y_ff[DATA_W-1]}}, y_ff};
            mul_b = {{(MUL_W-DATA_W){y_ff[DATA_W-1]}}, y_ff};
         end
         ST_CRS: begin
            mul_b = {{(MUL_W-DATA_W){y_ff[DATA_W-1]}}, y_ff};
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // adders around the product register
   assign origin_x_ext = {{(PROD_W-DATA_W){origin_x_ff[DATA_W-1]}}, origin_x_ff};
   assign origin_y_ext = {{(PROD_W-DATA_W){origin_y_ff[DATA_W-1]}}, origin_y_ff};
   assign c_real_ext   = {{(PROD_W-DATA_W){c_real_ff[DATA_W-1]}}, c_real_ff};
   assign c_imag_ext   = {{(PROD_W-DATA_W){c_imag_ff[DATA_W-1]}}, c_imag_ff};

   // escape test: in ST_CRS, xx_ff holds x*x and prod_ff holds y*y
   assign esc_sum  = xx_ff + prod_ff;
   assign escaped  = (esc_sum >= ESC_LIMIT);
   assign at_limit = (cnt_ff >= max_iter_ff);

   // update: in ST_UPD, prod_ff holds x*y; both shifts round toward minus infinity
   assign re_diff = xx_ff - yy_ff;
   assign re_shf  = re_diff >>> FRACTION_BITS;
   assign im_shf  = prod_ff >>> (FRACTION_BITS - 1);

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_MCX;
            end
         end
         ST_MCX: begin
            state_in = ST_MCY;
         end
         ST_MCY: begin
            c_real_in = sat32(origin_x_ext + prod_ff);
            state_in  = ST_LDC;
         end
         ST_LDC: begin
            c_imag_in = sat32(origin_y_ext + prod_ff);
            x_in      = c_real_ff;
            y_in      = c_imag_in;
            cnt_in    = '0;
            state_in  = ST_SQX;
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            state_in = ST_CRS;
         end
         ST_CRS: begin
            // limit and escape are tested together; either one ends the loop
            if (at_limit || escaped) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            x_in     = sat32(re_shf + c_real_ext);
            y_in     = sat32(im_shf + c_imag_ext);
            cnt_in   = cnt_ff + COUNT_W'(1);
            state_in = ST_SQX;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // view registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_X_RST;
         origin_y_ff <= ORIGIN_Y_RST;
         step_x_ff   <= STEP_X_RST;
         step_y_ff   <= STEP_Y_RST;
         max_iter_ff <= MAX_ITER_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ORIGIN_X: origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y: origin_y_ff <= csr_wdata;
            REG_STEP_X:   step_x_ff   <= csr_wdata[STEP_W-1:0];
            REG_STEP_Y:   step_y_ff   <= csr_wdata[STEP_W-1:0];
            REG_MAX_ITER: max_iter_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         col_ff <= req_pixel_column & COORD_MASK;
         row_ff <= req_pixel_row & COORD_MASK;
      end
      prod_ff <= prod_in;
      // x*x captured while y*y is formed, y*y while x*y is formed
      if (state_ff == ST_SQY) begin
         xx_ff <= prod_ff;
      end
      if (state_ff == ST_CRS) begin
         yy_ff <= prod_ff;
      end
      c_real_ff    <= c_real_in;
      c_imag_ff    <= c_imag_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

`default_nettype wire
